// File: hdl/assert_macros.svh
// Assertion macros used by the FFT core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/r2fft_pkg.sv
`timescale 1ns / 1ps
package r2fft_pkg;

   localparam int OUT_BITS    = 22;
   localparam int SAMPLE_BITS = 16;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PERM_RD,
      ST_PERM_WR,
      ST_BF_RD,
      ST_BF_WAIT,
      ST_BF_WR,
      ST_OUT
   } state_type;

   // Register indexes of the configuration port.
   localparam logic [0:0] REG_POINTS_LOG2 = 1'd0;
   localparam logic [0:0] REG_DIRECTION   = 1'd1;

   // Quarter-wave cosine table, scaled by 2^15.
   function automatic logic signed [16:0] cos_rom(input logic [4:0] m);
      logic signed [16:0] v;
      unique case (m)
         5'd0:  v = 17'sd32768;
         5'd1:  v = 17'sd32610;
         5'd2:  v = 17'sd32138;
         5'd3:  v = 17'sd31357;
         5'd4:  v = 17'sd30274;
         5'd5:  v = 17'sd28899;
         5'd6:  v = 17'sd27246;
         5'd7:  v = 17'sd25330;
         5'd8:  v = 17'sd23170;
         5'd9:  v = 17'sd20788;
         5'd10: v = 17'sd18205;
         5'd11: v = 17'sd15447;
         5'd12: v = 17'sd12540;
         5'd13: v = 17'sd9512;
         5'd14: v = 17'sd6393;
         5'd15: v = 17'sd3212;
         default: v = 17'sd0;
      endcase
      return v;
   endfunction

   // Saturates a wide sum into the output range.
   function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [23:0] v);
      logic signed [OUT_BITS-1:0] r;
      if (v > 24'sd2097151) begin
         r = 22'sd2097151;
      end else if (v < -24'sd2097152) begin
         r = -22'sd2097152;
      end else begin
         r = v[OUT_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/r2fft_store.sv
`timescale 1ns / 1ps
// Dual-port point memory: one write port and two registered read ports.
module r2fft_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 44
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [DW-1:0] rd_data_a,
   output logic [DW-1:0] rd_data_b
);

   logic [DW-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read ports.
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// File: hdl/r2fft_bfly.sv
`timescale 1ns / 1ps
// Butterfly unit: complex twiddle multiply, rounding, add and subtract.
// Stage one registers the four products, stage two combines.
module r2fft_bfly (
   input  logic                clock,
   input  logic signed [21:0]  ar,
   input  logic signed [21:0]  ai,
   input  logic signed [21:0]  br,
   input  logic signed [21:0]  bi,
   input  logic signed [16:0]  wc,
   input  logic signed [16:0]  ws,
   output logic signed [21:0]  sum_r,
   output logic signed [21:0]  sum_i,
   output logic signed [21:0]  dif_r,
   output logic signed [21:0]  dif_i
);

   logic signed [38:0] p_cr_ff, p_si_ff, p_ci_ff, p_sr_ff;
   logic signed [21:0] ar_ff, ai_ff;
   logic signed [40:0] tr_full, ti_full;
   logic signed [25:0] tr, ti;

   // Products.
   always_ff @(posedge clock) begin
      p_cr_ff <= wc * br;
      p_si_ff <= ws * bi;
      p_ci_ff <= wc * bi;
      p_sr_ff <= ws * br;
      ar_ff   <= ar;
      ai_ff   <= ai;
   end

   // Round to nearest, ties up, then add and subtract with saturation.
   always_comb begin
      tr_full = 41'(p_cr_ff) - 41'(p_si_ff) + 41'sd16384;
      ti_full = 41'(p_ci_ff) + 41'(p_sr_ff) + 41'sd16384;
      tr = tr_full[40:15];
      ti = ti_full[40:15];
      sum_r = r2fft_pkg::sat_out(24'(26'(ar_ff) + tr));
      sum_i = r2fft_pkg::sat_out(24'(26'(ai_ff) + ti));
      dif_r = r2fft_pkg::sat_out(24'(26'(ar_ff) - tr));
      dif_i = r2fft_pkg::sat_out(24'(26'(ai_ff) - ti));
   end

endmodule

// File: hdl/radix2_complex_fft_core.sv
`timescale 1ns / 1ps
// Radix-2 complex FFT core, in place over one point memory.
// The req_ channel carries one complex Q1.15 sample per beat. After N
// samples (N = 2^points_log2) the core stops taking beats, permutes the
// memory by bit reversal, runs log2(N) stages of N/2 butterflies (each
// a read, a multiply, then the sum and the difference written back on
// the single write port), then sends N bins in bin order on rsp_, the
// last marked by tlast. After the first bin is read, the bins go out one
// per cycle while rsp_ is ready. The write port sets the butterfly pace.
// A stalled rsp_ holds the current bin; the next bin read waits.
// Reset clears the load count and state and sets points_log2 to 6 and
// direction to 0; memory contents are undefined but never read unwritten.
// The csr_ port is APB, registers at byte addresses 0 and 4.
`include "assert_macros.svh"
module radix2_complex_fft_core #(
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: real_in[15:0], imag_in[31:16].
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: real_out[21:0], imag_out[43:22], bin_index[49:44].
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (MAX_POINTS >= 64) ? 6 : (MAX_POINTS >= 32) ? 5 :
                       (MAX_POINTS >= 16) ? 4 : (MAX_POINTS >= 8) ? 3 :
                       (MAX_POINTS >= 4) ? 2 : 1;
   localparam int LGMAX = AW;

   r2fft_pkg::state_type state_ff, state_in;
   logic [2:0]    lg_reg_ff;
   logic          dir_ff;
   logic [6:0]    load_ff, load_in;
   logic [2:0]    lg;
   logic [6:0]    n;
   logic [AW-1:0] idx_ff, idx_in;
   logic [2:0]    stage_ff, stage_in;
   logic [AW-1:0] bidx_ff, bidx_in;
   logic          half_ff, half_in;
   logic          out_v_ff, out_v_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_a, rd_b;
   logic [43:0]   wr_data, rd_da, rd_db;
   logic signed [21:0] sr, si, dr, di;
   logic signed [16:0] wc, ws, wx, wy;
   logic [5:0]    ang;
   logic [AW-1:0] rev, top, bot, kk, hmask;

   // Effective length, clamped.
   always_comb begin
      lg = lg_reg_ff;
      if (lg == 3'd0) lg = 3'd1;
      if (lg > 3'(LGMAX)) lg = 3'(LGMAX);
      n = 7'd1 << lg;
   end

   // Configuration port.
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         lg_reg_ff <= 3'd6;
         dir_ff    <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == {r2fft_pkg::REG_DIRECTION, 2'b00}) begin
            dir_ff <= csr_pwdata[0];
         end else if (csr_paddr == {r2fft_pkg::REG_POINTS_LOG2, 2'b00}) begin
            lg_reg_ff <= csr_pwdata[2:0];
         end
      end
   end
   assign csr_prdata = (csr_paddr == {r2fft_pkg::REG_DIRECTION, 2'b00}) ? {31'd0, dir_ff} :
                       (csr_paddr == {r2fft_pkg::REG_POINTS_LOG2, 2'b00}) ?
                       {29'd0, lg_reg_ff} : 32'd0;

   // Bit reversal of idx over lg bits.
   always_comb begin
      rev = '0;
      for (int i = 0; i < AW; i++) begin
         if (i < int'(lg)) rev[int'(lg) - 1 - i] = idx_ff[i];
      end
   end

   // Butterfly addressing: bidx enumerates pairs; insert a zero at bit stage.
   always_comb begin
      hmask = AW'((7'd1 << stage_ff) - 7'd1);
      kk    = bidx_ff & hmask;
      top   = ((bidx_ff & ~hmask) << 1) | kk;
      bot   = top | AW'(7'd1 << stage_ff);
      ang   = 6'((7'(kk) << (3'd5 - stage_ff)) & 7'd63);
      wx    = r2fft_pkg::cos_rom({1'b0, ang[3:0]});
      wy    = r2fft_pkg::cos_rom(5'd16 - 5'(ang[3:0]));
      unique case (ang[5:4])
         2'd0: begin wc = wx;  ws = wy;  end
         2'd1: begin wc = -wy; ws = wx;  end
         2'd2: begin wc = -wx; ws = -wy; end
         default: begin wc = wy;  ws = -wx; end
      endcase
      if (dir_ff) ws = -ws;
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      load_in  = load_ff;
      idx_in   = idx_ff;
      stage_in = stage_ff;
      bidx_in  = bidx_ff;
      half_in  = half_ff;
      unique case (state_ff)
         r2fft_pkg::ST_LOAD: begin
            if (req_tvalid) begin
               load_in = load_ff + 7'd1;
               if (load_in >= n) begin
                  load_in  = 7'd0;
                  idx_in   = '0;
                  state_in = r2fft_pkg::ST_PERM_RD;
               end
            end
         end
         r2fft_pkg::ST_PERM_RD: begin
            if (rev > idx_ff) begin
               state_in = r2fft_pkg::ST_PERM_WR;
               half_in  = 1'b0;
            end else if (7'(idx_ff) == n - 7'd1) begin
               state_in = r2fft_pkg::ST_BF_RD;
               stage_in = 3'd0;
               bidx_in  = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         r2fft_pkg::ST_PERM_WR: begin
            half_in = ~half_ff;
            if (half_ff) begin
               state_in = r2fft_pkg::ST_PERM_RD;
               idx_in   = idx_ff + 1'b1;
            end
         end
         r2fft_pkg::ST_BF_RD:   state_in = r2fft_pkg::ST_BF_WAIT;
         r2fft_pkg::ST_BF_WAIT: begin
            state_in = r2fft_pkg::ST_BF_WR;
            half_in  = 1'b0;
         end
         r2fft_pkg::ST_BF_WR: begin
            half_in = ~half_ff;
            if (half_ff) begin
               state_in = r2fft_pkg::ST_BF_RD;
               if (7'(bidx_ff) == (n >> 1) - 7'd1) begin
                  bidx_in  = '0;
                  stage_in = stage_ff + 3'd1;
                  if (stage_in == lg) begin
                     state_in = r2fft_pkg::ST_OUT;
                     idx_in   = '0;
                  end
               end else begin
                  bidx_in = bidx_ff + 1'b1;
               end
            end
         end
         r2fft_pkg::ST_OUT: begin
            if (out_v_ff && rsp_tready) begin
               if (7'(idx_ff) == n - 7'd1) begin
                  state_in = r2fft_pkg::ST_LOAD;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = r2fft_pkg::ST_LOAD;
      endcase
      // The bin at idx sits in the memory read register once the first read
      // made in ST_OUT has been registered.
      out_v_in = (state_ff == r2fft_pkg::ST_OUT) && (state_in == r2fft_pkg::ST_OUT);
   end

   // Output logic: memory ports.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = load_ff[AW-1:0];
      wr_data = {22'(signed'(req_tdata[r2fft_pkg::SAMPLE_BITS +: r2fft_pkg::SAMPLE_BITS])),
                 22'(signed'(req_tdata[0 +: r2fft_pkg::SAMPLE_BITS]))};
      rd_a    = idx_ff;
      rd_b    = rev;
      req_tready = (state_ff == r2fft_pkg::ST_LOAD);
      unique case (state_ff)
         r2fft_pkg::ST_LOAD: wr_en = req_tvalid;
         r2fft_pkg::ST_PERM_WR: begin
            wr_en   = 1'b1;
            wr_addr = half_ff ? rev : idx_ff;
            wr_data = half_ff ? rd_da : rd_db;
         end
         r2fft_pkg::ST_BF_RD, r2fft_pkg::ST_BF_WAIT: begin
            rd_a = top;
            rd_b = bot;
         end
         r2fft_pkg::ST_BF_WR: begin
            wr_en   = 1'b1;
            wr_addr = half_ff ? bot : top;
            wr_data = half_ff ? {di, dr} : {si, sr};
            rd_a    = top;
            rd_b    = bot;
         end
         // Read the bin that will be current next cycle; a stall holds it.
         r2fft_pkg::ST_OUT: rd_a = idx_in;
         default: ;
      endcase
   end

   r2fft_store #(.DEPTH(MAX_POINTS), .AW(AW), .DW(44)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr_a(rd_a), .rd_addr_b(rd_b), .rd_data_a(rd_da), .rd_data_b(rd_db)
   );

   r2fft_bfly u_bfly (
      .clock(clock),
      .ar(signed'(rd_da[21:0])), .ai(signed'(rd_da[43:22])),
      .br(signed'(rd_db[21:0])), .bi(signed'(rd_db[43:22])),
      .wc(wc), .ws(ws), .sum_r(sr), .sum_i(si), .dif_r(dr), .dif_i(di)
   );

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= r2fft_pkg::ST_LOAD;
         load_ff  <= 7'd0;
         idx_ff   <= '0;
         stage_ff <= 3'd0;
         bidx_ff  <= '0;
         half_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_ff  <= load_in;
         idx_ff   <= idx_in;
         stage_ff <= stage_in;
         bidx_ff  <= bidx_in;
         half_ff  <= half_in;
         out_v_ff <= out_v_in;
      end
   end

   // The memory read register carries the bin payload.
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {6'd0, 6'(idx_ff), rd_da};
   assign rsp_tlast  = (7'(idx_ff) == n - 7'd1);

   `ASSERT_IMPLY(a_no_accept_busy, clock, reset,
      state_ff != r2fft_pkg::ST_LOAD, !req_tready)
   `ASSERT_NEXT(a_load_wraps, clock, reset,
      req_tvalid && req_tready && (load_ff + 7'd1 >= n), state_ff == r2fft_pkg::ST_PERM_RD)
   `ASSERT_IMPLY(a_stage_bound, clock, reset,
      state_ff == r2fft_pkg::ST_BF_WR, stage_ff < lg)
   `ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

// File: tb/radix2_complex_fft_core_tb.sv
`timescale 1ns / 1ps
module radix2_complex_fft_core_tb;

   // One transform bin as seen on the rsp_ channel.
   typedef struct {
      logic signed [21:0] re;
      logic signed [21:0] im;
      logic [5:0]         bin;
      logic               last;
   } bin_type;

   // One row of the directed table. Rows with has_bins set complete a
   // two-point frame whose bins are typed in (sum and difference).
   typedef struct {
      logic [2:0]         lg;
      logic               dir;
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               has_bins;
      int                 b0_re;
      int                 b0_im;
      int                 b1_re;
      int                 b1_im;
   } step_type;

   typedef enum int {FRAME_NOISE, FRAME_TONE, FRAME_SHORT} frame_kind_type;

   localparam int NUM_STEPS = 25;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state: point memory, load count and register copies.
   longint      pt_re [64];
   longint      pt_im [64];
   int unsigned pt_loaded;
   logic [2:0]  cur_lg;
   logic        cur_dir;
   bin_type     pending_bins [$];

   int          fail_count;
   int          mismatch_count;
   int          stall_left;
   bit          quiet;

   const int cos_table [17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
      23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

   const step_type steps [NUM_STEPS] = '{
      '{3'd1, 1'b1,  16'sh7fff, -16'sh8000, 1'b0, 0, 0, 0, 0},
      '{3'd1, 1'b1,  16'sh7fff, -16'sh8000, 1'b1, 65534, -65536, 0, 0},
      '{3'd1, 1'b1, -16'sh8000,  16'sh7fff, 1'b0, 0, 0, 0, 0},
      '{3'd1, 1'b1,  16'sh7fff, -16'sh8000, 1'b1, -1, -1, -65535, 65535},
      // A length of zero acts as two points.
      '{3'd0, 1'b1,  16'sd0,     16'sd0,    1'b0, 0, 0, 0, 0},
      '{3'd0, 1'b1,  16'sd1,    -16'sd1,    1'b1, 1, -1, -1, 1},
      '{3'd2, 1'b1,  16'sh7fff,  16'sd0,    1'b0, 0, 0, 0, 0},
      '{3'd2, 1'b1,  16'sd0,     16'sh7fff, 1'b0, 0, 0, 0, 0},
      '{3'd2, 1'b1, -16'sh8000,  16'sd0,    1'b0, 0, 0, 0, 0},
      '{3'd2, 1'b1,  16'sd0,    -16'sh8000, 1'b0, 0, 0, 0, 0},
      // A length above the maximum acts as the maximum; then shrink mid-frame.
      '{3'd7, 1'b0,  16'sd100,   16'sd200,  1'b0, 0, 0, 0, 0},
      '{3'd7, 1'b0, -16'sd300,   16'sd400,  1'b0, 0, 0, 0, 0},
      '{3'd7, 1'b0,  16'sh7fff, -16'sh8000, 1'b0, 0, 0, 0, 0},
      '{3'd2, 1'b0,  16'sh1234,  16'sh4321, 1'b0, 0, 0, 0, 0},
      // Load count already past the new length.
      '{3'd6, 1'b0,  16'sd5,     16'sd6,    1'b0, 0, 0, 0, 0},
      '{3'd6, 1'b0,  16'sd7,     16'sd8,    1'b0, 0, 0, 0, 0},
      '{3'd6, 1'b0, -16'sd9,     16'sd10,   1'b0, 0, 0, 0, 0},
      '{3'd1, 1'b0,  16'sd11,   -16'sd12,   1'b0, 0, 0, 0, 0},
      '{3'd3, 1'b0,  16'sh7fff,  16'sh7fff, 1'b0, 0, 0, 0, 0},
      '{3'd3, 1'b0, -16'sh8000,  16'sh7fff, 1'b0, 0, 0, 0, 0},
      '{3'd3, 1'b0, -16'sh8000, -16'sh8000, 1'b0, 0, 0, 0, 0},
      '{3'd3, 1'b0,  16'sh7fff, -16'sh8000, 1'b0, 0, 0, 0, 0},
      '{3'd3, 1'b0,  16'sh5555,  16'shaaaa, 1'b0, 0, 0, 0, 0},
      '{3'd3, 1'b0,  16'shaaaa,  16'sh5555, 1'b0, 0, 0, 0, 0},
      '{3'd3, 1'b0,  16'sd1,     16'sd2,    1'b0, 0, 0, 0, 0}
   };

   radix2_complex_fft_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Clamp a 64-bit butterfly sum to the 22-bit output range.
   function automatic longint clamp22(input longint v);
      if (v > 64'sd2097151) begin
         return 64'sd2097151;
      end
      if (v < -64'sd2097152) begin
         return -64'sd2097152;
      end
      return v;
   endfunction

   // Run the in-place transform on the first 2^lg points and queue the bins.
   task automatic compute_spectrum(input int lg);
      int      n;
      int      i;
      int      j;
      int      k;
      int      stage;
      int      half;
      int      ang;
      int      quad;
      int      frac;
      longint  x;
      longint  y;
      longint  wc;
      longint  ws;
      longint  tr;
      longint  ti;
      longint  ar;
      longint  ai;
      bin_type b;
      n = 1 << lg;
      // Bit-reversed reorder.
      for (i = 0; i < n; i++) begin
         j = 0;
         for (k = 0; k < lg; k++) begin
            j |= ((i >> k) & 1) << (lg - 1 - k);
         end
         if (j > i) begin
            x = pt_re[i]; pt_re[i] = pt_re[j]; pt_re[j] = x;
            x = pt_im[i]; pt_im[i] = pt_im[j]; pt_im[j] = x;
         end
      end
      // Butterfly stages with rounded twiddle products.
      for (stage = 0; stage < lg; stage++) begin
         half = 1 << stage;
         for (k = 0; k < half; k++) begin
            ang = (k << (5 - stage)) & 63;
            quad = ang >> 4;
            frac = ang & 15;
            x = cos_table[frac];
            y = cos_table[16 - frac];
            case (quad)
               0: begin wc = x;  ws = y;  end
               1: begin wc = -y; ws = x;  end
               2: begin wc = -x; ws = -y; end
               default: begin wc = y; ws = -x; end
            endcase
            if (cur_dir) begin
               ws = -ws;
            end
            for (i = k; i < n; i += 2 * half) begin
               j = i + half;
               tr = (wc * pt_re[j] - ws * pt_im[j] + 16384) >>> 15;
               ti = (wc * pt_im[j] + ws * pt_re[j] + 16384) >>> 15;
               ar = pt_re[i];
               ai = pt_im[i];
               pt_re[j] = clamp22(ar - tr);
               pt_im[j] = clamp22(ai - ti);
               pt_re[i] = clamp22(ar + tr);
               pt_im[i] = clamp22(ai + ti);
            end
         end
      end
      for (i = 0; i < n; i++) begin
         b.re = pt_re[i][21:0];
         b.im = pt_im[i][21:0];
         b.bin = i[5:0];
         b.last = (i == n - 1);
         pending_bins.push_back(b);
      end
   endtask

   // Store one accepted sample and start a transform when the frame is full.
   task automatic load_point(input logic signed [15:0] re, input logic signed [15:0] im);
      int lg;
      lg = cur_lg;
      if (lg < 1) begin
         lg = 1;
      end
      if (lg > 6) begin
         lg = 6;
      end
      pt_re[pt_loaded & 63] = re;
      pt_im[pt_loaded & 63] = im;
      pt_loaded = (pt_loaded + 1) & 127;
      if (pt_loaded >= (1 << lg)) begin
         pt_loaded = 0;
         compute_spectrum(lg);
      end
   endtask

   // Send one sample beat, with an optional idle burst before it.
   task automatic send_point(input logic signed [15:0] re, input logic signed [15:0] im);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {im, re};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      load_point(re, im);
   endtask

   // Write one register once all bins are out and the core has settled.
   task automatic write_reg(input logic [0:0] index, input logic [31:0] value);
      req_tvalid <= 1'b0;
      wait (pending_bins.size() == 0);
      repeat (20) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == r2fft_pkg::REG_POINTS_LOG2) begin
         cur_lg = value[2:0];
      end else begin
         cur_dir = value[0];
      end
   endtask

   task automatic set_config(input logic [2:0] lg, input logic dir);
      if (lg != cur_lg) begin
         write_reg(r2fft_pkg::REG_POINTS_LOG2, {29'd0, lg});
      end
      if (dir != cur_dir) begin
         write_reg(r2fft_pkg::REG_DIRECTION, {31'd0, dir});
      end
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return -16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   // Receiver stalls in random bursts until the quiet tail.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= int'($urandom_range(1, 7));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each bin beat with the oldest predicted bin.
   always @(posedge clock) begin
      bin_type want;
      bin_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.re = rsp_tdata[21:0];
         got.im = rsp_tdata[43:22];
         got.bin = rsp_tdata[49:44];
         got.last = rsp_tlast;
         if (pending_bins.size() == 0) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected bin beat: re %0d im %0d bin %0d last %0d",
                  got.re, got.im, got.bin, got.last);
            end
         end else begin
            want = pending_bins.pop_front();
            if (got.re !== want.re || got.im !== want.im || got.bin !== want.bin
                  || got.last !== want.last) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("bin mismatch: expected re %0d im %0d bin %0d last %0d,",
                     want.re, want.im, want.bin, want.last);
                  $display("   got re %0d im %0d bin %0d last %0d",
                     got.re, got.im, got.bin, got.last);
               end
            end
         end
      end
   end

   // Stimulus: reset, directed table, then random frames.
   initial begin
      int             row;
      int             sent;
      int             i;
      int             n;
      int             lg;
      frame_kind_type kind;
      bin_type        b1;
      bin_type        b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      quiet = 1'b0;
      fail_count = 0;
      mismatch_count = 0;
      pt_loaded = 0;
      cur_lg = 3'd6;
      cur_dir = 1'b0;
      for (i = 0; i < 64; i++) begin
         pt_re[i] = 0;
         pt_im[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part; two-point rows carry their bins inline.
      for (row = 0; row < NUM_STEPS; row++) begin
         set_config(steps[row].lg, steps[row].dir);
         send_point(steps[row].re, steps[row].im);
         if (steps[row].has_bins) begin
            void'(pending_bins.pop_back());
            void'(pending_bins.pop_back());
            b0.re = steps[row].b0_re;
            b0.im = steps[row].b0_im;
            b0.bin = 6'd0;
            b0.last = 1'b0;
            b1.re = steps[row].b1_re;
            b1.im = steps[row].b1_im;
            b1.bin = 6'd1;
            b1.last = 1'b1;
            pending_bins.push_back(b0);
            pending_bins.push_back(b1);
         end
      end

      // Random frames, mostly short, a few at the full length.
      sent = 0;
      while (sent < 175) begin
         case ($urandom_range(0, 9))
            0: lg = 6;
            1: lg = 5;
            2: lg = 0;
            3: lg = 7;
            default: lg = $urandom_range(1, 4);
         endcase
         set_config(lg[2:0], 1'($urandom_range(0, 1)));
         if (lg < 1) begin
            lg = 1;
         end
         if (lg > 6) begin
            lg = 6;
         end
         n = 1 << lg;
         case ($urandom_range(0, 9))
            0: kind = FRAME_TONE;
            1: kind = FRAME_SHORT;
            default: kind = FRAME_NOISE;
         endcase
         if (sent + n >= 175) begin
            kind = FRAME_NOISE;
         end
         if (sent >= 130) begin
            quiet = 1'b1;
         end
         if (kind == FRAME_SHORT) begin
            n = (n > 1) ? $urandom_range(1, n - 1) : 1;
         end
         for (i = 0; i < n; i++) begin
            if (kind == FRAME_TONE) begin
               // A quarter-turn per point piles energy into one bin.
               case (i & 3)
                  0: send_point(16'sh7fff, 16'sh7fff);
                  1: send_point(-16'sh7fff, 16'sh7fff);
                  2: send_point(-16'sh7fff, -16'sh7fff);
                  default: send_point(16'sh7fff, -16'sh7fff);
               endcase
            end else begin
               send_point(pick_sample(), pick_sample());
            end
         end
         sent += n;
      end

      // Drain the remaining bins, then let the core settle.
      req_tvalid <= 1'b0;
      wait (pending_bins.size() == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: radix2_complex_fft_core.f
+incdir+hdl
hdl/r2fft_pkg.sv
hdl/r2fft_store.sv
hdl/r2fft_bfly.sv
hdl/radix2_complex_fft_core.sv
tb/radix2_complex_fft_core_tb.sv
